@@ src/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and codes for the stable max priority queue
// Command and status codes, sequencer states and the result bundle that
// travels from the sequencer to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

    // field widths of one item
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned RANK_W  = 16;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned OCC_W   = 4;
    localparam int unsigned SLOT_W  = VALUE_W + RANK_W;

    // request commands
    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    // one finished result
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] value;
        logic signed [RANK_W-1:0]  rank;
        logic [OCC_W-1:0]          occupancy;
    } result_t;

endpackage

`default_nettype wire

@@ src/smpq_ram.sv @@
// ----------------------------------------------------------------------------
// smpq_ram: slot storage
// One write port, one read port with registered read data. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3,
    parameter int unsigned DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/smpq_seq.sv @@
// ----------------------------------------------------------------------------
// smpq_seq: request sequencer
// Holds the entry count and walks the slot memory: a scan that reads one
// entry per cycle, with one shared signed rank compare, finds the oldest
// maximum, then a read/write loop closes the gap behind the removed entry.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_seq #(
    parameter int unsigned CAPACITY = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // request side
    input  wire logic                                  req_valid,
    output logic                                       req_ready,
    input  wire logic [smpq_pkg::CMD_W-1:0]            req_command,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]   req_value,
    input  wire logic signed [smpq_pkg::RANK_W-1:0]    req_rank,
    // result side
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output smpq_pkg::result_t                          res
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    smpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic signed [smpq_pkg::RANK_W-1:0]  best_rank_reg, best_rank_next;
    logic signed [smpq_pkg::VALUE_W-1:0] best_value_reg, best_value_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic [smpq_pkg::STAT_W-1:0]         stat_reg, stat_next;
    logic signed [smpq_pkg::VALUE_W-1:0] rvalue_reg, rvalue_next;
    logic signed [smpq_pkg::RANK_W-1:0]  rrank_reg, rrank_next;

    logic                          we;
    logic [IW-1:0]                 waddr;
    logic [smpq_pkg::SLOT_W-1:0]   wdata;
    logic [IW-1:0]                 raddr;
    logic [smpq_pkg::SLOT_W-1:0]   rdata;
    logic signed [smpq_pkg::VALUE_W-1:0] rd_value;
    logic signed [smpq_pkg::RANK_W-1:0]  rd_rank;
    logic [CW-1:0]                 idx_plus1;
    logic                          rank_gt;
    logic [CW+3:0]                 occ_ext;

    smpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (smpq_pkg::SLOT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // slot layout: rank in the upper bits, value in the lower
    assign rd_value  = rdata[smpq_pkg::VALUE_W-1:0];
    assign rd_rank   = rdata[smpq_pkg::SLOT_W-1:smpq_pkg::VALUE_W];
    assign idx_plus1 = idx_reg + 1'b1;

    // shared compare unit
    assign rank_gt = rd_rank > best_rank_reg;

    // result bundle
    assign occ_ext       = {4'b0000, count_reg};
    assign res.status    = stat_reg;
    assign res.value     = rvalue_reg;
    assign res.rank      = rrank_reg;
    assign res.occupancy = occ_ext[smpq_pkg::OCC_W-1:0];
    assign res_valid     = (state_reg == smpq_pkg::ST_DONE);
    assign req_ready     = (state_reg == smpq_pkg::ST_IDLE);

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smpq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        best_rank_reg  <= best_rank_next;
        best_value_reg <= best_value_next;
        best_idx_reg   <= best_idx_next;
        stat_reg       <= stat_next;
        rvalue_reg     <= rvalue_next;
        rrank_reg      <= rrank_next;
    end

    // next state and memory control
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_rank_next  = best_rank_reg;
        best_value_next = best_value_reg;
        best_idx_next   = best_idx_reg;
        stat_next       = stat_reg;
        rvalue_next     = rvalue_reg;
        rrank_next      = rrank_reg;
        we              = 1'b0;
        waddr           = idx_reg[IW-1:0];
        wdata           = rdata;
        raddr           = '0;

        unique case (state_reg)
            smpq_pkg::ST_IDLE: begin
                // slot 0 is read while idle, for peek and the first scan step
                raddr = '0;
                if (req_valid) begin
                    stat_next   = smpq_pkg::STAT_OK;
                    rvalue_next = '0;
                    rrank_next  = '0;
                    idx_next    = '0;
                    state_next  = smpq_pkg::ST_DONE;
                    if (req_command == smpq_pkg::CMD_ENQ) begin
                        if (count_reg == CAP_C) begin
                            stat_next = smpq_pkg::STAT_FULL;
                        end else begin
                            we         = 1'b1;
                            waddr      = count_reg[IW-1:0];
                            wdata      = {req_rank, req_value};
                            count_next = count_reg + 1'b1;
                        end
                    end else if (req_command == smpq_pkg::CMD_DEQ) begin
                        if (count_reg == '0) begin
                            stat_next = smpq_pkg::STAT_EMPTY;
                        end else begin
                            state_next = smpq_pkg::ST_SCAN;
                        end
                    end else if (req_command == smpq_pkg::CMD_PEEK) begin
                        if (count_reg == '0) begin
                            stat_next = smpq_pkg::STAT_EMPTY;
                        end else begin
                            state_next = smpq_pkg::ST_PEEK;
                        end
                    end
                end
            end

            smpq_pkg::ST_PEEK: begin
                rvalue_next = rd_value;
                rrank_next  = rd_rank;
                state_next  = smpq_pkg::ST_DONE;
            end

            // rdata holds slot idx_reg; strict greater keeps the oldest max
            smpq_pkg::ST_SCAN: begin
                raddr = idx_plus1[IW-1:0];
                if (idx_reg == '0 || rank_gt) begin
                    best_rank_next  = rd_rank;
                    best_value_next = rd_value;
                    best_idx_next   = idx_reg;
                end
                if (idx_plus1 == count_reg) begin
                    idx_next   = (idx_reg == '0 || rank_gt) ? idx_reg : best_idx_reg;
                    state_next = smpq_pkg::ST_SHIFT_RD;
                end else begin
                    idx_next = idx_plus1;
                end
            end

            // move slot idx+1 down to idx until the young end is reached
            smpq_pkg::ST_SHIFT_RD: begin
                if (idx_plus1 < count_reg) begin
                    raddr      = idx_plus1[IW-1:0];
                    state_next = smpq_pkg::ST_SHIFT_WR;
                end else begin
                    count_next  = count_reg - 1'b1;
                    rvalue_next = best_value_reg;
                    rrank_next  = best_rank_reg;
                    state_next  = smpq_pkg::ST_DONE;
                end
            end

            smpq_pkg::ST_SHIFT_WR: begin
                we         = 1'b1;
                waddr      = idx_reg[IW-1:0];
                wdata      = rdata;
                idx_next   = idx_plus1;
                state_next = smpq_pkg::ST_SHIFT_RD;
            end

            smpq_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = smpq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = smpq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/stable_max_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// stable_max_priority_queue_core: bounded max priority queue, stable order
// Each input item is one request (enqueue, dequeue highest rank, peek
// oldest); each request gives exactly one result item.
//
// Input channel s_*: tuser carries the command, tdata the value and rank.
// Result channel m_*: tuser carries the status, tdata the returned value,
// rank and the entry count after the request.
// Enqueue, empty and unknown requests go straight to the result; a peek
// first reads slot 0; a dequeue scans all n stored entries and then moves
// each entry behind the removed slot b down by one, n-1-b moves in all.
// The dequeue scan reads the slot memory one entry per cycle through its
// single read port, and closing the gap takes a read and a write per moved
// entry. One request is worked on at a time; s_tready is high only while
// the sequencer is idle, including while a finished result waits in the
// output register. A stalled receiver holds the result in that register.
// After reset the queue is empty and m_tvalid is low; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_max_priority_queue_core #(
    parameter int unsigned CAPACITY = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_rank
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [31:0] out_value, [47:32] out_rank,
                                        // [51:48] occupancy, [55:52] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    logic              res_valid;
    logic              res_ready;
    smpq_pkg::result_t res;
    logic              m_tvalid_reg;
    logic [55:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    smpq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_command (s_tuser),
        .req_value   (s_tdata[31:0]),
        .req_rank    (s_tdata[47:32]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register: loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {4'b0000, res.occupancy, res.rank, res.value};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ test/stable_max_priority_queue_core_test.sv @@
// ----------------------------------------------------------------------------
// stable_max_priority_queue_core_test: self-checking bench for the queue core
// Drives enqueue, dequeue, peek and unused requests through the s_* stream.
// A scoreboard keeps its own copy of the stored entries in arrival order and
// works out the expected result item for every accepted request. Each result
// item taken from the m_* stream is checked field by field against the oldest
// expected one. The run has a short directed part, then random traffic that
// swings between filling and draining the queue under three idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_max_priority_queue_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int unsigned DRAIN_WAIT  = 3 * QUEUE_DEPTH + 16;
    localparam int unsigned MAX_REPORTS = 10;

    // request code with no meaning; the core must leave the queue alone
    localparam logic [smpq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: shadow queue plus expected result items
    // ------------------------------------------------------------------------
    class pq_scoreboard;
        logic [smpq_pkg::VALUE_W-1:0]       slot_value [QUEUE_DEPTH];
        logic signed [smpq_pkg::RANK_W-1:0] slot_rank  [QUEUE_DEPTH];
        int unsigned                        held;
        smpq_pkg::result_t                  awaited [$];
        int unsigned                        mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        // apply one accepted request to the shadow queue, record its result
        function void note_request(logic [smpq_pkg::CMD_W-1:0] cmd,
                                   logic [smpq_pkg::VALUE_W-1:0] val,
                                   logic [smpq_pkg::RANK_W-1:0] rnk);
            smpq_pkg::result_t res;
            int unsigned       best;
            res.status    = smpq_pkg::STAT_OK;
            res.value     = '0;
            res.rank      = '0;
            case (cmd)
                smpq_pkg::CMD_ENQ: begin
                    if (held >= QUEUE_DEPTH) begin
                        res.status = smpq_pkg::STAT_FULL;
                    end else begin
                        slot_value[held] = val;
                        slot_rank[held]  = rnk;
                        held++;
                    end
                end
                smpq_pkg::CMD_DEQ: begin
                    if (held == 0) begin
                        res.status = smpq_pkg::STAT_EMPTY;
                    end else begin
                        // strict compare keeps the oldest among equal ranks
                        best = 0;
                        for (int unsigned i = 1; i < held; i++) begin
                            if (slot_rank[i] > slot_rank[best])
                                best = i;
                        end
                        res.value = slot_value[best];
                        res.rank  = slot_rank[best];
                        for (int unsigned i = best; i + 1 < held; i++) begin
                            slot_value[i] = slot_value[i + 1];
                            slot_rank[i]  = slot_rank[i + 1];
                        end
                        held--;
                    end
                end
                smpq_pkg::CMD_PEEK: begin
                    if (held == 0) begin
                        res.status = smpq_pkg::STAT_EMPTY;
                    end else begin
                        res.value = slot_value[0];
                        res.rank  = slot_rank[0];
                    end
                end
                default: ;
            endcase
            res.occupancy = held[smpq_pkg::OCC_W-1:0];
            awaited.push_back(res);
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch on %s: expected %0h, got %0h",
                         $realtime, what, exp_v, got_v);
        endfunction

        // compare one result item with the oldest expectation
        function void check_result(logic [smpq_pkg::STAT_W-1:0] status,
                                   logic [smpq_pkg::VALUE_W-1:0] value,
                                   logic [smpq_pkg::RANK_W-1:0] rank,
                                   logic [smpq_pkg::OCC_W-1:0] occupancy,
                                   logic [3:0] pad);
            smpq_pkg::result_t exp_res;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result item with nothing expected: status %0h",
                             $realtime, status);
                return;
            end
            exp_res = awaited.pop_front();
            if (status !== exp_res.status)
                report("status", 64'(exp_res.status), 64'(status));
            if (value !== exp_res.value)
                report("out_value", 64'(exp_res.value), 64'(value));
            if (rank !== exp_res.rank)
                report("out_rank", 64'(exp_res.rank), 64'(rank));
            if (occupancy !== exp_res.occupancy)
                report("occupancy", 64'(exp_res.occupancy), 64'(occupancy));
            if (pad !== 4'd0)
                report("tdata padding", 64'd0, 64'(pad));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // [31:0] item_value, [47:32] item_rank
    logic [1:0]  s_tuser  = '0;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // [31:0] out_value, [47:32] out_rank,
                                   // [51:48] occupancy, [55:52] zero
    logic [1:0]  m_tuser;          // [1:0] status

    int unsigned  send_idle_pct = 10;
    int unsigned  recv_idle_pct = 55;
    int unsigned  cycle_count   = 0;
    pq_scoreboard queue_model   = new();

    stable_max_priority_queue_core #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stable_max_priority_queue_core_test: FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, check every accepted item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            queue_model.check_result(m_tuser, m_tdata[31:0], m_tdata[47:32],
                                     m_tdata[51:48], m_tdata[55:52]);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_request(logic [smpq_pkg::CMD_W-1:0] cmd,
                                logic [smpq_pkg::VALUE_W-1:0] val,
                                logic [smpq_pkg::RANK_W-1:0] rnk);
        // random gap before the item
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rnk, val};
        do
            @(posedge aclk);
        while (!s_tready);
        queue_model.note_request(cmd, val, rnk);
    endtask

    // ranks: half from a narrow band so ties are common
    function automatic logic [smpq_pkg::RANK_W-1:0] pick_rank();
        logic [smpq_pkg::RANK_W-1:0] rnk;
        case ($urandom_range(3))
            0, 1: rnk = smpq_pkg::RANK_W'($urandom_range(3)) - 16'd2;
            2:    rnk = smpq_pkg::RANK_W'($urandom);
            default: begin
                case ($urandom_range(3))
                    0:       rnk = 16'h7fff;
                    1:       rnk = 16'h8000;
                    2:       rnk = 16'h0000;
                    default: rnk = 16'hffff;
                endcase
            end
        endcase
        return rnk;
    endfunction

    // random traffic that alternates between filling and draining
    task automatic run_random(int unsigned count);
        bit                         filling;
        int unsigned                tide_left;
        int unsigned                roll;
        logic [smpq_pkg::CMD_W-1:0] cmd;
        filling   = 1'b1;
        tide_left = 0;
        for (int unsigned n = 0; n < count; n++) begin
            if (tide_left == 0) begin
                filling   = ~filling;
                tide_left = $urandom_range(10, 40);
            end
            tide_left--;
            roll = $urandom_range(99);
            if (roll < 5)
                cmd = CMD_UNUSED;
            else if (roll < 15)
                cmd = smpq_pkg::CMD_PEEK;
            else if (roll < (filling ? 75 : 40))
                cmd = smpq_pkg::CMD_ENQ;
            else
                cmd = smpq_pkg::CMD_DEQ;
            send_request(cmd, smpq_pkg::VALUE_W'($urandom), pick_rank());
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queue, extreme fields, ties, full queue, drain
        send_request(smpq_pkg::CMD_PEEK, 32'h0000_0000, 16'h0000);
        send_request(smpq_pkg::CMD_DEQ,  32'h0000_0000, 16'h0000);
        send_request(CMD_UNUSED,         32'hdead_beef, 16'h1234);
        send_request(smpq_pkg::CMD_ENQ,  32'h7fff_ffff, 16'h7fff);
        send_request(smpq_pkg::CMD_ENQ,  32'h8000_0000, 16'h8000);
        send_request(smpq_pkg::CMD_ENQ,  32'h0000_0000, 16'h0000);
        send_request(smpq_pkg::CMD_ENQ,  32'hffff_ffff, 16'hffff);
        send_request(smpq_pkg::CMD_ENQ,  32'ha5a5_a5a5, 16'h7fff);
        send_request(smpq_pkg::CMD_ENQ,  32'h5a5a_5a5a, 16'h8000);
        send_request(smpq_pkg::CMD_ENQ,  32'h0000_0001, 16'h0000);
        send_request(smpq_pkg::CMD_ENQ,  32'h0000_0002, 16'h7fff);
        send_request(smpq_pkg::CMD_ENQ,  32'h0000_0003, 16'h0001);    // queue full
        send_request(smpq_pkg::CMD_PEEK, 32'hffff_ffff, 16'hffff);
        send_request(CMD_UNUSED,         32'hffff_ffff, 16'hffff);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(smpq_pkg::CMD_DEQ, 32'h0000_0000, 16'h0000);
        send_request(smpq_pkg::CMD_DEQ,  32'h0000_0000, 16'h0000);
        send_request(smpq_pkg::CMD_PEEK, 32'h0000_0000, 16'h0000);

        // random traffic under three idle patterns
        run_random(700);
        send_idle_pct = 55;
        recv_idle_pct = 10;
        run_random(700);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(600);
        s_tvalid <= 1'b0;

        while (queue_model.awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (queue_model.mismatches == 0 && queue_model.awaited.size() == 0) begin
            $display("stable_max_priority_queue_core_test: PASS");
        end else begin
            $display("stable_max_priority_queue_core_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
